FILE: hdl/spisrd_pkg.sv
package spisrd_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 128;

	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SELF_ADDRESS  = 2'd0;
	localparam cfg_idx_t CFG_MAX_REGISTERS = 2'd1;

	localparam logic [7:0] SELF_ADDRESS_RST  = 8'd1;
	localparam logic [6:0] MAX_REGISTERS_RST = 7'd32;

	localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'h10;
	localparam int         BASE_FRAME_LEN      = 8;
	localparam int         WRITE_MULTI_OVERHEAD = 9;
	localparam int         BYTE_COUNT_INDEX    = 6;
	localparam int         ADDRESS_INDEX       = 0;
	localparam int         FUNCTION_INDEX      = 1;
	localparam int         COUNT_HIGH_INDEX    = 4;
	localparam int         COUNT_LOW_INDEX     = 5;

	typedef enum logic [1:0] {
		EV_SELECT_FALL = 2'd0,
		EV_SELECT_RISE = 2'd1,
		EV_BYTE        = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		ST_IGNORED     = 3'd0,
		ST_STORED      = 3'd1,
		ST_COMPLETE    = 3'd2,
		ST_ADDR_DROP   = 3'd3,
		ST_LENGTH_ERR  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic       byte_stored;
		logic [6:0] byte_index;
		logic [7:0] byte_data;
		logic [7:0] frame_length;
	} res_t;

	typedef struct packed {
		logic [7:0] self_address;
		logic [6:0] max_registers;
	} cfg_t;

endpackage

FILE: hdl/spisrd_if.sv
interface spisrd_req_if;
	import spisrd_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface spisrd_res_if;
	import spisrd_pkg::*;
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface spisrd_cfg_if;
	import spisrd_pkg::*;
	logic       valid;
	logic       ready;
	cfg_idx_t   index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/spi_slave_request_deframer_core.sv
// A request accepted into the input register has its result loaded into the result
// register when the pipeline advances, and the result is offered from there.
// Throughput: one request per cycle while results are taken; the input register and the result register
// move together, so a stalled result holds one more request in the input register.
// Frame state is updated in the single decision stage between the two registers.
// Reset (arst_n low, asynchronous): idle phase, empty pipeline, default configuration.
module spi_slave_request_deframer_core #(
	parameter int MAX_FRAME_BYTES = spisrd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	spisrd_req_if.sink  req,
	spisrd_res_if.source res,
	spisrd_cfg_if.sink  cfg
);
	import spisrd_pkg::*;

	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	res_t res_s2;

	cfg_t regs;
	res_t result;
	logic advance;

	assign advance   = !valid_s2 || res.ready;
	assign req.ready = !valid_s1 || advance;

	spisrd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	spisrd_frame_fsm #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (regs),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (advance && valid_s1) begin
			res_s2 <= result;
		end
	end

	assign res.valid   = valid_s2;
	assign res.payload = res_s2;

endmodule

FILE: hdl/spisrd_cfg_regs.sv
module spisrd_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	spisrd_cfg_if.sink          cfg,
	output spisrd_pkg::cfg_t    regs
);
	import spisrd_pkg::*;

	logic [7:0] self_address_q;
	logic [6:0] max_registers_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_address_q  <= SELF_ADDRESS_RST;
			max_registers_q <= MAX_REGISTERS_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_SELF_ADDRESS) begin
				self_address_q <= cfg.data;
			end
			if (cfg.index == CFG_MAX_REGISTERS) begin
				max_registers_q <= cfg.data[6:0];
			end
		end
	end

	assign regs.self_address  = self_address_q;
	assign regs.max_registers = max_registers_q;

endmodule

FILE: hdl/spisrd_frame_fsm.sv
module spisrd_frame_fsm #(
	parameter int MAX_FRAME_BYTES = spisrd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  spisrd_pkg::req_t    item,
	input  spisrd_pkg::cfg_t    cfg,
	output spisrd_pkg::res_t    result
);
	import spisrd_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);
	localparam logic [17:0]      MAX_LEN = 18'(MAX_FRAME_BYTES);

	phase_t           phase_q, phase_nx;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [CNT_W-1:0] exp_q, exp_nx;
	logic [7:0]       addr_q, func_q, cnt_hi_q, cnt_lo_q;

	logic             take;
	logic [CNT_W-1:0] count_inc;
	logic [15:0]      regs;
	logic [17:0]      len_full;
	logic             check_len;
	logic             len_err;
	logic [CNT_W-1:0] exp_eff;
	logic             reach;
	logic             mismatch;

	assign take = fire && (item.func == EV_BYTE) && (phase_q == PH_RECV) &&
		(count_q < MAX_CNT);
	assign count_inc = count_q + CNT_W'(1);
	assign regs      = {cnt_hi_q, cnt_lo_q};
	assign len_full  = 18'(WRITE_MULTI_OVERHEAD) + {1'b0, regs, 1'b0};
	assign check_len = (count_q == CNT_W'(BYTE_COUNT_INDEX)) &&
		(func_q == FUNC_WRITE_MULTIPLE);
	assign len_err   = check_len && ((regs == 16'd0) ||
		(item.rx_byte != {cnt_lo_q[6:0], 1'b0}) ||
		(regs > {9'd0, cfg.max_registers}) || (len_full > MAX_LEN));
	assign exp_eff   = check_len ? len_full[CNT_W-1:0] : exp_q;
	assign reach     = count_inc >= exp_eff;
	assign mismatch  = addr_q != cfg.self_address;

	always_comb begin
		phase_nx = phase_q;
		count_nx = count_q;
		exp_nx   = exp_q;
		if (fire) begin
			unique case (item.func)
				EV_SELECT_FALL: begin
					phase_nx = PH_RECV;
					count_nx = '0;
					exp_nx   = CNT_W'(BASE_FRAME_LEN);
				end
				EV_SELECT_RISE: begin
					phase_nx = PH_IDLE;
					count_nx = '0;
				end
				default: begin
					if (take) begin
						count_nx = count_inc;
						exp_nx   = exp_eff;
						if (len_err) begin
							phase_nx = PH_DONE;
						end else if (reach) begin
							phase_nx = mismatch ? PH_DROP : PH_DONE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			exp_q   <= CNT_W'(BASE_FRAME_LEN);
		end else begin
			phase_q <= phase_nx;
			count_q <= count_nx;
			exp_q   <= exp_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (count_q == CNT_W'(ADDRESS_INDEX)) begin
				addr_q <= item.rx_byte;
			end
			if (count_q == CNT_W'(FUNCTION_INDEX)) begin
				func_q <= item.rx_byte;
			end
			if (count_q == CNT_W'(COUNT_HIGH_INDEX)) begin
				cnt_hi_q <= item.rx_byte;
			end
			if (count_q == CNT_W'(COUNT_LOW_INDEX)) begin
				cnt_lo_q <= item.rx_byte;
			end
		end
	end

	always_comb begin
		result = '0;
		result.status = ST_IGNORED;
		if (take) begin
			result.byte_stored = 1'b1;
			result.byte_index  = 7'(count_q);
			result.byte_data   = item.rx_byte;
			if (len_err) begin
				result.status = ST_LENGTH_ERR;
			end else if (reach) begin
				result.status       = mismatch ? ST_ADDR_DROP : ST_COMPLETE;
				result.frame_length = 8'(count_inc);
			end else begin
				result.status = ST_STORED;
			end
		end
	end

endmodule
